// File: rtl/drcm_pkg.sv
// ============================================================================
// drcm_pkg - shared types and constants of the depth rainbow colormap
// Holds the field widths, the configuration register codes, the beat types
// passed between pipeline parts and the rainbow ROM built at elaboration.
// ============================================================================
package drcm_pkg;

    localparam int LUT_ENTRIES = 256;
    localparam int LUT_SPAN    = LUT_ENTRIES - 1;
    localparam int IDX_W       = $clog2(LUT_ENTRIES);
    localparam int STOP_COUNT  = 6;
    localparam int CHAN_W      = 8;

    localparam int DIST_W      = 16;
    // 2*(d-min)*255 + den fits below 2^(DIST_W + IDX_W + 1)
    localparam int NUM_W       = DIST_W + IDX_W + 1;
    // front stages, one divider stage per index bit, output register
    localparam int PIPE_DEPTH  = 2 + IDX_W + 1;

    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_MM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_MM  = 1'b1;

    localparam logic [DIST_W-1:0] NEAR_MM_RST = 16'd0;
    localparam logic [DIST_W-1:0] FAR_MM_RST  = 16'd10000;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_bgr;

    typedef t_bgr [LUT_ENTRIES-1:0] t_rom;

    // Beat entering and travelling through the divider
    typedef struct packed {
        logic              black;
        logic [NUM_W-1:0]  rem;
        logic [DIST_W-1:0] den;
    } t_div_beat;

    // Beat leaving the divider
    typedef struct packed {
        logic             black;
        logic [IDX_W-1:0] index;
    } t_idx_beat;

    localparam t_bgr RAINBOW_STOPS [STOP_COUNT] = '{
        '{8'd255, 8'd0,   8'd0},    // blue
        '{8'd255, 8'd255, 8'd0},    // cyan
        '{8'd0,   8'd255, 8'd255},  // yellow
        '{8'd0,   8'd165, 8'd255},  // orange
        '{8'd0,   8'd0,   8'd255},  // red
        '{8'd64,  8'd64,  8'd128}   // violet
    };

    function automatic logic [CHAN_W-1:0] lerp_channel(input logic [CHAN_W-1:0] lo,
                                                       input logic [CHAN_W-1:0] hi,
                                                       input int r);
        int v;
        v = ((LUT_SPAN - r) * int'(lo) + r * int'(hi)) / LUT_SPAN;
        return v[CHAN_W-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        int   pos;
        int   seg;
        int   r;
        int   up;
        rom = '0;
        for (int i = 0; i < LUT_ENTRIES; i++) begin
            pos = i * (STOP_COUNT - 1);
            seg = pos / LUT_SPAN;
            r   = pos - seg * LUT_SPAN;
            up  = seg + 1;
            if (seg > STOP_COUNT - 1) begin
                seg = STOP_COUNT - 1;
                r   = 0;
            end
            if (up > STOP_COUNT - 1) begin
                up = STOP_COUNT - 1;
            end
            rom[i].blue  = lerp_channel(RAINBOW_STOPS[seg].blue,  RAINBOW_STOPS[up].blue,  r);
            rom[i].green = lerp_channel(RAINBOW_STOPS[seg].green, RAINBOW_STOPS[up].green, r);
            rom[i].red   = lerp_channel(RAINBOW_STOPS[seg].red,   RAINBOW_STOPS[up].red,   r);
        end
        return rom;
    endfunction

    localparam t_rom RAINBOW_ROM = build_rom();

endpackage

// File: rtl/drcm_if.sv
// ============================================================================
// drcm_if - stream channels of the depth rainbow colormap
// Depth channel carries one signed depth sample a beat, pixel channel one
// BGR pixel a beat; both use valid/ready.
// ============================================================================
interface drcm_depth_if #(
    parameter int DEPTH_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DEPTH_BITS-1:0] depth;

    modport source (output valid, output depth, input ready);
    modport sink   (input valid, input depth, output ready);
endinterface

interface drcm_pixel_if ();
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

// File: rtl/depth_rainbow_colormap_unit.sv
// ============================================================================
// depth_rainbow_colormap_unit - depth sample to rainbow BGR pixel
// Maps each signed depth sample onto a blue-to-violet color ramp.
// ============================================================================
// Usage:
//   i_depth  : valid/ready stream of signed depth samples in millimetres.
//   o_pixel  : valid/ready stream of BGR pixels, one per depth beat, in order.
//   i_cfg_*  : write port for the near limit (index 0) and the far limit
//              (index 1); write only while no beat is in flight.
//   A depth of zero or below gives black. Other depths are clamped to
//   [min, max] and mapped to round((d-min)*255/(max-min)); an empty or
//   inverted range gives blue.
// Timing:
//   Eleven register stages: two front stages, eight divider stages (one
//   quotient bit each) and the output register. One beat per cycle is
//   sustained while o_pixel is not stalled.
// Reset:
//   Synchronous, active low; empties the pipeline and restores the registers
//   to min 0 mm and max 10000 mm.
// Stall:
//   A stalled output holds its pixel; beats behind it close up into empty
//   stages and i_depth.ready drops only once every stage is full.
// ============================================================================
module depth_rainbow_colormap_unit
    import drcm_pkg::*;
#(
    parameter int DEPTH_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    drcm_depth_if.sink           i_depth,
    drcm_pixel_if.source         o_pixel,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIST_W-1:0]    i_cfg_data
);

    logic [DIST_W-1:0] r_near_mm;
    logic [DIST_W-1:0] r_far_mm;

    logic      front_valid;
    logic      front_ready;
    t_div_beat front_beat;
    logic      div_valid;
    logic      div_ready;
    t_idx_beat div_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_mm <= NEAR_MM_RST;
            r_far_mm  <= FAR_MM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NEAR_MM: r_near_mm <= i_cfg_data;
                CFG_FAR_MM:  r_far_mm  <= i_cfg_data;
            endcase
        end
    end

    drcm_front #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_depth   (i_depth),
        .i_near_mm (r_near_mm),
        .i_far_mm  (r_far_mm),
        .o_valid   (front_valid),
        .i_ready   (front_ready),
        .o_beat    (front_beat)
    );

    drcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_beat  (front_beat),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_beat  (div_beat)
    );

    drcm_lut u_lut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_ready (div_ready),
        .i_beat  (div_beat),
        .o_pixel (o_pixel)
    );

endmodule

// File: rtl/drcm_front.sv
// ============================================================================
// drcm_front - validity check, clamp and numerator build
// Stage 1 flags invalid depth and clamps it into the distance range.
// Stage 2 forms the rounding numerator 2*(d-min)*255 + den for the divider.
// ============================================================================
module drcm_front
    import drcm_pkg::*;
#(
    parameter int DEPTH_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    drcm_depth_if.sink         i_depth,
    input  logic [DIST_W-1:0]  i_near_mm,
    input  logic [DIST_W-1:0]  i_far_mm,
    output logic               o_valid,
    input  logic               i_ready,
    output t_div_beat          o_beat
);

    logic                  r1_valid;
    logic                  r1_black;
    logic [DIST_W-1:0]     r1_diff;
    logic [DIST_W-1:0]     r1_den;
    logic                  r2_valid;
    t_div_beat             r2_beat;

    logic                  ready1;
    logic                  ready2;
    logic [DEPTH_BITS-1:0] depth_u;
    logic [DEPTH_BITS-1:0] min_ext;
    logic [DEPTH_BITS-1:0] max_ext;
    logic [DEPTH_BITS-1:0] offset;
    logic                  nonpos;
    logic                  range_ok;
    logic [DIST_W-1:0]     n_diff;
    logic [DIST_W-1:0]     n_den;
    logic [NUM_W-1:0]      n_num;

    assign ready2        = !r2_valid || i_ready;
    assign ready1        = !r1_valid || ready2;
    assign i_depth.ready = ready1;

    assign depth_u  = i_depth.depth;
    assign min_ext  = DEPTH_BITS'(i_near_mm);
    assign max_ext  = DEPTH_BITS'(i_far_mm);
    assign offset   = depth_u - min_ext;
    assign nonpos   = depth_u[DEPTH_BITS-1] || (depth_u == '0);
    assign range_ok = i_far_mm > i_near_mm;

    // An empty range uses den = 1 with zero offset so the quotient comes out 0
    always_comb begin
        n_den = range_ok ? (i_far_mm - i_near_mm) : DIST_W'(1);
        if (!range_ok || (depth_u < min_ext)) begin
            n_diff = '0;
        end else if (depth_u > max_ext) begin
            n_diff = n_den;
        end else begin
            n_diff = offset[DIST_W-1:0];
        end
    end

    assign n_num = NUM_W'(r1_diff) * NUM_W'(2 * LUT_SPAN) + NUM_W'(r1_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (ready1) begin
                r1_valid <= i_depth.valid;
            end
            if (ready2) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_depth.valid) begin
            r1_black <= nonpos;
            r1_diff  <= n_diff;
            r1_den   <= n_den;
        end
        if (ready2 && r1_valid) begin
            r2_beat.black <= r1_black;
            r2_beat.rem   <= n_num;
            r2_beat.den   <= r1_den;
        end
    end

    assign o_valid = r2_valid;
    assign o_beat  = r2_beat;

endmodule

// File: rtl/drcm_div.sv
// ============================================================================
// drcm_div - pipelined restoring divider
// One quotient bit per stage, MSB first: subtract (2*den) << k from the
// running remainder when it fits. The quotient is the rounded LUT index.
// ============================================================================
module drcm_div
    import drcm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_beat i_beat,
    output logic      o_valid,
    input  logic      i_ready,
    output t_idx_beat o_beat
);

    logic             r_valid [IDX_W];
    t_div_beat        r_beat  [IDX_W];
    logic [IDX_W-1:0] r_quo   [IDX_W];
    logic [IDX_W:0]   w_ready;

    // a stage takes a beat when it is empty or its own beat moves on
    always_comb begin
        w_ready[IDX_W] = i_ready;
        for (int s = IDX_W - 1; s >= 0; s--) begin
            w_ready[s] = !r_valid[s] || w_ready[s+1];
        end
    end

    for (genvar s = 0; s < IDX_W; s++) begin : g_stage
        localparam int Shift = IDX_W - 1 - s;

        logic             v_in;
        t_div_beat        b_in;
        logic [IDX_W-1:0] q_in;
        logic [NUM_W-1:0] sub;
        logic [NUM_W:0]   trial;

        if (s == 0) begin : g_head
            assign v_in = i_valid;
            assign b_in = i_beat;
            assign q_in = '0;
        end else begin : g_body
            assign v_in = r_valid[s-1];
            assign b_in = r_beat[s-1];
            assign q_in = r_quo[s-1];
        end

        assign sub   = NUM_W'({b_in.den, 1'b0}) << Shift;
        assign trial = {1'b0, b_in.rem} - {1'b0, sub};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (w_ready[s]) begin
                r_valid[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ready[s] && v_in) begin
                r_beat[s].black <= b_in.black;
                r_beat[s].den   <= b_in.den;
                if (!trial[NUM_W]) begin
                    r_beat[s].rem <= trial[NUM_W-1:0];
                    r_quo[s]      <= q_in | (IDX_W'(1) << Shift);
                end else begin
                    r_beat[s].rem <= b_in.rem;
                    r_quo[s]      <= q_in;
                end
            end
        end
    end

    assign o_ready      = w_ready[0];
    assign o_valid      = r_valid[IDX_W-1];
    assign o_beat.black = r_beat[IDX_W-1].black;
    assign o_beat.index = r_quo[IDX_W-1];

endmodule

// File: rtl/drcm_lut.sv
// ============================================================================
// drcm_lut - rainbow lookup and output register
// Reads the 256-entry rainbow ROM at the index, forces black for invalid
// depth, and holds the pixel until the receiver takes it.
// ============================================================================
module drcm_lut
    import drcm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_idx_beat    i_beat,
    drcm_pixel_if.source o_pixel
);

    logic r_valid;
    t_bgr r_pix;
    logic ready;

    assign ready   = !r_valid || o_pixel.ready;
    assign o_ready = ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_pix <= i_beat.black ? t_bgr'('0) : RAINBOW_ROM[i_beat.index];
        end
    end

    assign o_pixel.valid = r_valid;
    assign o_pixel.blue  = r_pix.blue;
    assign o_pixel.green = r_pix.green;
    assign o_pixel.red   = r_pix.red;

endmodule

// File: rtl/drcm_checker.sv
// ============================================================================
// drcm_checker - port-level assertions for the depth rainbow colormap
// Tracks beats in flight and checks reset, stall holding, in-flight limits and colors.
// ============================================================================
module drcm_checker
    import drcm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_blue,
    input logic [7:0] i_green,
    input logic [7:0] i_red
);

    localparam int CntW = $clog2(PIPE_DEPTH + 1);

    logic [CntW-1:0] r_inflight;
    logic [CntW-1:0] n_inflight;
    logic            in_acc;
    logic            out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_inflight = r_inflight;
        if (in_acc && !out_acc) begin
            n_inflight = r_inflight + CntW'(1);
        end else if (out_acc && !in_acc) begin
            n_inflight = r_inflight - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_blue, i_green, i_red}))
        else $error("stalled pixel changed or dropped");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_inflight != '0)
        else $error("pixel delivered with no depth beat in flight");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CntW'(PIPE_DEPTH))
        else $error("more beats in flight than pipeline stages");

    // on the ramp, red is zero only in the blue-to-cyan stretch
    a_ramp_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_red == 8'd0 |->
            i_blue == 8'd255 || (i_blue == 8'd0 && i_green == 8'd0))
        else $error("pixel color is off the rainbow ramp");

endmodule

bind depth_rainbow_colormap_unit drcm_checker u_drcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_depth.valid),
    .i_in_ready  (i_depth.ready),
    .i_out_valid (o_pixel.valid),
    .i_out_ready (o_pixel.ready),
    .i_blue      (o_pixel.blue),
    .i_green     (o_pixel.green),
    .i_red       (o_pixel.red)
);

// File: tb/tb_depth_rainbow_colormap_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_depth_rainbow_colormap_unit - self-checking bench of the rainbow colormap
// Streams signed depth beats through the block under several distance
// ranges (reset, narrow, full, empty, inverted, random) with random gaps on
// the depth side and random stalls on the pixel side. A scoreboard predicts
// every BGR pixel from its own rainbow table and compares each field.
// ============================================================================
module tb_depth_rainbow_colormap_unit
    import drcm_pkg::*;
();

    localparam int DEPTH_W      = 24;
    localparam int RANGE_ITEMS  = 125;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = PIPE_DEPTH + 4;

    typedef logic signed [DEPTH_W-1:0] t_depth;

    class rainbow_scoreboard;
        t_bgr              ramp [LUT_ENTRIES];
        logic [DIST_W-1:0] near_mm;
        logic [DIST_W-1:0] far_mm;
        t_bgr              expected_pixels [$];
        int                errors;
        int                pixels_checked;
        int                black_count;

        function new();
            int stops [STOP_COUNT][3];
            int seg;
            int off;
            int up;
            int lane [3];
            stops = '{'{255, 0, 0}, '{255, 255, 0}, '{0, 255, 255},
                      '{0, 165, 255}, '{0, 0, 255}, '{64, 64, 128}};
            // six stops at 51-entry spacing, channels truncated toward zero
            for (int i = 0; i < LUT_ENTRIES; i++) begin
                seg = (5 * i) / 255;
                off = 5 * i - 255 * seg;
                up  = (seg < STOP_COUNT - 1) ? seg + 1 : STOP_COUNT - 1;
                for (int c = 0; c < 3; c++) begin
                    lane[c] = ((255 - off) * stops[seg][c] + off * stops[up][c]) / 255;
                end
                ramp[i].blue  = lane[0][7:0];
                ramp[i].green = lane[1][7:0];
                ramp[i].red   = lane[2][7:0];
            end
            near_mm        = NEAR_MM_RST;
            far_mm         = FAR_MM_RST;
            errors         = 0;
            pixels_checked = 0;
            black_count    = 0;
        endfunction

        function void write_range(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] data);
            if (idx == CFG_NEAR_MM) begin
                near_mm = data;
            end else begin
                far_mm = data;
            end
        endfunction

        function t_bgr color_of(t_depth d);
            longint dv;
            longint den;
            longint num;
            longint slot;
            if (d <= 0) begin
                return '0;
            end
            slot = 0;
            if (far_mm > near_mm) begin
                dv = longint'(d);
                if (dv < longint'(near_mm)) dv = longint'(near_mm);
                if (dv > longint'(far_mm)) dv = longint'(far_mm);
                den  = longint'(far_mm) - longint'(near_mm);
                num  = (dv - longint'(near_mm)) * 255;
                // round to nearest, ties up
                slot = (2 * num + den) / (2 * den);
                if (slot > LUT_ENTRIES - 1) slot = LUT_ENTRIES - 1;
            end
            return ramp[slot];
        endfunction

        function void note_depth(t_depth d);
            if (d <= 0) black_count++;
            expected_pixels.insert(expected_pixels.size(), color_of(d));
        endfunction

        function bit field_ok(string lane, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, lane, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_pixel(t_bgr got);
            t_bgr want;
            bit   ok;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected none actual b=%0d g=%0d r=%0d",
                         $time, got.blue, got.green, got.red);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            ok   = field_ok("blue", want.blue, got.blue);
            ok   = field_ok("green", want.green, got.green) && ok;
            ok   = field_ok("red", want.red, got.red) && ok;
            if (!ok) errors++;
            pixels_checked++;
        endfunction

        function void close_out();
            if (expected_pixels.size() != 0) begin
                $display("%0t: %0d pixels expected, actual none arrived",
                         $time, expected_pixels.size());
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DIST_W-1:0]    cfg_data;

    drcm_depth_if #(.DEPTH_BITS(DEPTH_W)) depth_ch ();
    drcm_pixel_if                         pixel_ch ();

    rainbow_scoreboard sb;
    bit                quiet_mode = 1'b0;
    int                cycle_count = 0;
    int                ranges_run = 0;

    depth_rainbow_colormap_unit #(
        .DEPTH_BITS (DEPTH_W)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_depth    (depth_ch),
        .o_pixel    (pixel_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_depth pick_depth(int lo, int hi);
        int a;
        int b;
        int v;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        case ($urandom_range(0, 19))
            0: begin
                v = 0;
            end
            1: begin
                v = -int'($urandom_range(1, 8388608));
            end
            2: begin
                v = $urandom;
            end
            3: begin
                v = $urandom_range(65536, 8388607);
            end
            4, 5: begin
                case ($urandom_range(0, 5))
                    0: v = a - 1;
                    1: v = a;
                    2: v = a + 1;
                    3: v = b - 1;
                    4: v = b;
                    default: v = b + 1;
                endcase
            end
            default: begin
                v = $urandom_range(a, b);
            end
        endcase
        return v[DEPTH_W-1:0];
    endfunction

    // pixel side: ready runs broken by random stalls
    initial begin
        int run;
        int hold;
        pixel_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            run = quiet_mode ? 64 : $urandom_range(1, 16);
            pixel_ch.ready <= 1'b1;
            repeat (run) @(negedge clk);
            hold = quiet_mode ? 0 : pick_gap();
            if (hold > 0) begin
                pixel_ch.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && pixel_ch.valid && pixel_ch.ready) begin
            sb.check_pixel('{blue: pixel_ch.blue, green: pixel_ch.green, red: pixel_ch.red});
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d pixels outstanding",
                     $time, cycle_count, sb.expected_pixels.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Called at a falling edge; returns at a falling edge with valid untouched there.
    task automatic send_depth(t_depth d);
        int gap;
        gap = quiet_mode ? 0 : pick_gap();
        depth_ch.valid <= 1'b1;
        depth_ch.depth <= d;
        do @(posedge clk); while (!depth_ch.ready);
        sb.note_depth(d);
        @(negedge clk);
        if (gap > 0) begin
            depth_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        depth_ch.valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge clk);
        @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_range(logic [DIST_W-1:0] lo, logic [DIST_W-1:0] hi);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_NEAR_MM;
        cfg_data <= lo;
        @(negedge clk);
        cfg_idx  <= CFG_FAR_MM;
        cfg_data <= hi;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.write_range(CFG_NEAR_MM, lo);
        sb.write_range(CFG_FAR_MM, hi);
    endtask

    task automatic run_range(int lo, int hi);
        set_range(lo[DIST_W-1:0], hi[DIST_W-1:0]);
        for (int n = 0; n < RANGE_ITEMS; n++) begin
            // now and then a stretch with no gaps or stalls at all
            if (n % 40 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
            send_depth(pick_depth(lo, hi));
        end
        quiet_mode = 1'b0;
        ranges_run++;
    endtask

    initial begin
        t_depth at_reset [13];
        t_depth narrow [7];
        int     lo;
        int     hi;
        sb             = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_NEAR_MM;
        cfg_data       = '0;
        depth_ch.valid = 1'b0;
        depth_ch.depth = '0;
        // zero, negatives, field extremes, round-up tie at 1000, range ends
        at_reset = '{0, -1, 24'h800000, 24'h7FFFFF, 1, 19, 20, 1000,
                     5000, 9999, 10000, 10001, 3000};
        // index equals d - 2000 across this range
        narrow   = '{1999, 2000, 2001, 2127, 2255, 2256, 1};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (at_reset[k]) send_depth(at_reset[k]);
        set_range(16'd2000, 16'd2255);
        foreach (narrow[k]) send_depth(narrow[k]);

        run_range(0, 10000);
        run_range(0, 65535);
        run_range(0, 1);
        lo = $urandom_range(0, 65534);
        hi = $urandom_range(lo + 1, 65535);
        run_range(lo, hi);
        run_range(500, 500);
        run_range(65535, 0);
        run_range(65534, 65535);
        run_range($urandom_range(0, 65535), $urandom_range(0, 65535));
        run_range(0, 255);
        lo = $urandom_range(0, 60000);
        run_range(lo, lo + $urandom_range(1, 600));

        drain();
        sb.close_out();
        $display("Checked %0d pixels (%0d black) over the reset range, one directed range",
                 sb.pixels_checked, sb.black_count);
        $display("and %0d random ranges including empty, inverted and full-scale ones.",
                 ranges_run);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
